// ===== src/brb_pkg.sv =====
// Shared types and codes for the byte ring buffer.
package brb_pkg;

  localparam int CW = 7;

  localparam logic [2:0] REQ_ENQ  = 3'd0;
  localparam logic [2:0] REQ_DEQ  = 3'd1;
  localparam logic [2:0] REQ_GET  = 3'd2;
  localparam logic [2:0] REQ_CLR  = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;
  localparam logic [2:0] REQ_COPY = 3'd5;

  typedef struct packed {
    logic [2:0]    req_type;
    logic [7:0]    data_in;
    logic [5:0]    offset;
    logic [CW-1:0] elem_size;
    logic [CW-1:0] elem_count;
  } brb_req_t;

  typedef struct packed {
    logic          ok;
    logic          data_valid;
    logic [7:0]    data_out;
    logic [CW-1:0] elems_done;
    logic [CW-1:0] fill_level;
    logic          last;
  } brb_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_DIV,
    S_MUL,
    S_SETUP,
    S_STREAM
  } brb_state_t;

endpackage

// ===== src/byte_ring_buffer.sv =====
// Byte ring buffer top level: circular FIFO with single-byte and bulk element requests.
//
// Byte-wide circular FIFO over 1..DEPTH slots (the capacity register, clamped to
// that range; writing it empties the buffer). One request is taken at a time on
// the req channel; req_ready is high only while the sequencer is idle. Enqueue,
// dequeue, get-at-offset, discard and unused codes each produce one transfer on
// the rsp channel; the result of an accepted request is loaded into the output
// register on the next cycle that register is free, and only then can the next
// request be accepted. Read and copy of elements first work out min(elem_count,
// fill / elem_size) on a shared restoring divider, one quotient bit per cycle,
// then a multiply state works out the byte count and a setup state prepares the
// stream; after that the bytes stream out one per cycle while rsp_ready lets the
// output register advance, straight from the store's registered read port (the
// read address looks one byte ahead when the output register advances), with
// last set on the final byte. A bulk request that moves no whole element returns
// a single transfer with ok low. The output register lets the next request be
// accepted while the previous result still waits on rsp_ready.
// Every result carries the fill level as it stands after the whole request.
module byte_ring_buffer
  import brb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  brb_req_t      req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output brb_rsp_t      rsp,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // control state
  brb_state_t    state, state_next;
  logic [CW-1:0] capacity, capacity_next;
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] rp, rp_next;
  logic          full, full_next;
  logic          rsp_valid_next;

  // payload / working registers
  logic [AW-1:0] pos, pos_next;        // store address whose byte sits in rd_data
  brb_rsp_t      res, res_next;        // pending single result
  brb_rsp_t      rsp_next;
  logic [2:0]    op, op_next;
  logic [CW-1:0] esize, esize_next;
  logic [CW-1:0] ecount, ecount_next;
  logic [CW-1:0] rem, rem_next;        // divider remainder
  logic [CW-1:0] quo, quo_next;        // dividend shifting out, quotient shifting in
  logic [2:0]    dstep, dstep_next;
  logic [CW-1:0] elems, elems_next;
  logic [CW-1:0] nbytes, nbytes_next;
  logic [CW-1:0] bytes_left, bytes_left_next;
  logic [CW-1:0] fill_after, fill_after_next;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic          mem_we;

  logic          accept;
  logic          out_load;
  logic [CW-1:0] fill;
  logic [CW-1:0] gsum;
  logic [AW-1:0] gaddr;
  logic [CW:0]   dtrial;
  logic [CW-1:0] elems_c;
  logic [2*CW-1:0] prod;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= c) ? '0 : AW'(n);
  endfunction

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_load  = ((state == S_EMIT) || (state == S_STREAM)) && (!rsp_valid || rsp_ready);

  // bytes held now
  always_comb begin
    if (full) begin
      fill = capacity;
    end else if (wp >= rp) begin
      fill = CW'(wp) - CW'(rp);
    end else begin
      fill = capacity - (CW'(rp) - CW'(wp));
    end
  end

  // get address: rp + offset wraps at most once for any offset below the fill level
  assign gsum  = CW'(rp) + CW'(req.offset);
  assign gaddr = (gsum >= capacity) ? AW'(gsum - capacity) : AW'(gsum);

  // divider trial subtract and element count
  assign dtrial  = {rem, quo[CW-1]};
  assign elems_c = ((esize == '0) || (ecount == '0)) ? '0 :
                   ((quo < ecount) ? quo : ecount);
  assign prod    = (2*CW)'(elems_c) * (2*CW)'(esize);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type inside {REQ_READ, REQ_COPY}) state_next = S_DIV;
          else state_next = S_EMIT;
        end
      end
      S_DIV: begin
        if (dstep == 3'(CW - 1)) state_next = S_MUL;
      end
      S_MUL:   state_next = S_SETUP;
      S_SETUP: state_next = (elems == '0) ? S_EMIT : S_STREAM;
      S_EMIT: begin
        if (out_load) state_next = S_IDLE;
      end
      S_STREAM: begin
        if (out_load && (bytes_left == CW'(1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    capacity_next   = capacity;
    wp_next         = wp;
    rp_next         = rp;
    full_next       = full;
    pos_next        = pos;
    res_next        = res;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    op_next         = op;
    esize_next      = esize;
    ecount_next     = ecount;
    rem_next        = rem;
    quo_next        = quo;
    dstep_next      = dstep;
    elems_next      = elems;
    nbytes_next     = nbytes;
    bytes_left_next = bytes_left;
    fill_after_next = fill_after;
    mem_we          = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next            = '0;
          res_next.last       = 1'b1;
          res_next.fill_level = fill;
          op_next             = req.req_type;
          esize_next          = req.elem_size;
          ecount_next         = req.elem_count;
          rem_next            = '0;
          quo_next            = fill;
          dstep_next          = '0;
          case (req.req_type)
            REQ_ENQ: begin
              if (!full) begin
                mem_we              = 1'b1;
                wp_next             = wrap_inc(wp, capacity);
                full_next           = (wp_next == rp);
                res_next.ok         = 1'b1;
                res_next.fill_level = fill + CW'(1);
              end
            end
            REQ_DEQ: begin
              if (fill != '0) begin
                pos_next            = rp;
                rp_next             = wrap_inc(rp, capacity);
                full_next           = 1'b0;
                res_next.ok         = 1'b1;
                res_next.data_valid = 1'b1;
                res_next.fill_level = fill - CW'(1);
              end
            end
            REQ_GET: begin
              if (CW'(req.offset) < fill) begin
                pos_next            = gaddr;
                res_next.ok         = 1'b1;
                res_next.data_valid = 1'b1;
              end
            end
            REQ_CLR: begin
              wp_next             = '0;
              rp_next             = '0;
              full_next           = 1'b0;
              res_next.ok         = 1'b1;
              res_next.fill_level = '0;
            end
            REQ_READ, REQ_COPY: begin
              pos_next = rp;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (dtrial >= {1'b0, esize}) begin
          rem_next = CW'(dtrial - {1'b0, esize});
          quo_next = {quo[CW-2:0], 1'b1};
        end else begin
          rem_next = dtrial[CW-1:0];
          quo_next = {quo[CW-2:0], 1'b0};
        end
        dstep_next = dstep + 3'd1;
      end
      S_MUL: begin
        elems_next  = elems_c;
        nbytes_next = prod[CW-1:0];
      end
      S_SETUP: begin
        bytes_left_next = nbytes;
        fill_after_next = (op == REQ_READ) ? fill - nbytes : fill;
      end
      S_EMIT: begin
        if (out_load) begin
          rsp_next          = res;
          rsp_next.data_out = res.data_valid ? rd_data : '0;
          rsp_valid_next    = 1'b1;
        end
      end
      S_STREAM: begin
        if (out_load) begin
          rsp_next.ok         = 1'b1;
          rsp_next.data_valid = 1'b1;
          rsp_next.data_out   = rd_data;
          rsp_next.elems_done = elems;
          rsp_next.fill_level = fill_after;
          rsp_next.last       = (bytes_left == CW'(1));
          rsp_valid_next      = 1'b1;
          pos_next            = wrap_inc(pos, capacity);
          bytes_left_next     = bytes_left - CW'(1);
          // a consuming read commits the read pointer after its final byte
          if ((bytes_left == CW'(1)) && (op == REQ_READ)) begin
            rp_next   = pos_next;
            full_next = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // capacity write empties the buffer
    if (cfg_we) begin
      if (cfg_data == '0) capacity_next = CW'(1);
      else if (cfg_data > DEPTH_C) capacity_next = DEPTH_C;
      else capacity_next = cfg_data;
      wp_next   = '0;
      rp_next   = '0;
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= DEPTH_C;
      wp        <= '0;
      rp        <= '0;
      full      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      capacity  <= capacity_next;
      wp        <= wp_next;
      rp        <= rp_next;
      full      <= full_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    res        <= res_next;
    rsp        <= rsp_next;
    op         <= op_next;
    esize      <= esize_next;
    ecount     <= ecount_next;
    rem        <= rem_next;
    quo        <= quo_next;
    dstep      <= dstep_next;
    elems      <= elems_next;
    nbytes     <= nbytes_next;
    bytes_left <= bytes_left_next;
    fill_after <= fill_after_next;
  end

  // byte store: one write port, registered read that always tracks pos
  always_ff @(posedge clk) begin
    if (mem_we) mem[wp] <= req.data_in;
    rd_data <= mem[pos_next];
  end

endmodule
